// File: hdl/spc_pkg.sv
// ----------------------------------------------------------------------------
// spc_pkg: shared types and constants of the skin pixel classifier
// Thresholds of the RGB skin rule, hue arithmetic widths and pipeline buses.
// ----------------------------------------------------------------------------
`default_nettype none

package spc_pkg;

    localparam int unsigned PIX_W = 8;

    // RGB rule thresholds.
    localparam logic [PIX_W-1:0] DAY_R_MIN   = 8'd95;
    localparam logic [PIX_W-1:0] DAY_G_MIN   = 8'd40;
    localparam logic [PIX_W-1:0] DAY_B_MIN   = 8'd20;
    localparam logic [PIX_W-1:0] DIFF_LIMIT  = 8'd15;
    localparam logic [PIX_W-1:0] FLASH_R_MIN = 8'd220;
    localparam logic [PIX_W-1:0] FLASH_G_MIN = 8'd210;
    localparam logic [PIX_W-1:0] FLASH_B_MIN = 8'd170;

    // Hue arithmetic: the numerator stays below 2**17 and the quotient below 2**9.
    localparam int unsigned NUM_W  = 17;
    localparam int unsigned CALC_W = NUM_W + 2;
    localparam int unsigned QUO_W  = 9;
    localparam int unsigned HUE_W  = 9;

    localparam logic [HUE_W-1:0] HUE_FULL   = 9'd360;
    localparam logic [HUE_W-1:0] BASE_RED   = 9'd360;
    localparam logic [HUE_W-1:0] BASE_GREEN = 9'd120;
    localparam logic [HUE_W-1:0] BASE_BLUE  = 9'd240;
    localparam logic [HUE_W-1:0] HUE_SCALE  = 9'd60;

    // Divider pipeline: quotient bits resolved per stage, and stage count.
    localparam int unsigned DIV_STEPS  = 3;
    localparam int unsigned DIV_STAGES = (QUO_W + DIV_STEPS - 1) / DIV_STEPS;

    // Configuration registers.
    localparam int unsigned   CFG_IDX_W = 1;
    localparam logic [HUE_W-1:0] HUE_LOW_RESET  = 9'd25;
    localparam logic [HUE_W-1:0] HUE_HIGH_RESET = 9'd230;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HUE_LOW  = 1'b0,
        CFG_HUE_HIGH = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MAX_RED,
        MAX_GREEN,
        MAX_BLUE
    } t_max_sel;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             rgb_ok;
    } t_pix;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [PIX_W-1:0] den;
        logic [QUO_W-1:0] quo;
    } t_div_bus;

endpackage

`default_nettype wire

// File: hdl/spc_div_stage.sv
// ----------------------------------------------------------------------------
// spc_div_stage: one registered stage of the hue divider
// Resolves DIV_STEPS quotient bits by restoring division, highest bit first.
// ----------------------------------------------------------------------------
`default_nettype none

module spc_div_stage #(
    parameter int unsigned STAGE = 0
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  spc_pkg::t_div_bus i_bus,
    output spc_pkg::t_div_bus o_bus
);
    import spc_pkg::*;

    t_div_bus r_bus;
    t_div_bus n_bus;

    always_comb begin
        logic [NUM_W-1:0] trial;
        int               bitpos;
        n_bus = i_bus;
        for (int j = 0; j < int'(DIV_STEPS); j++) begin
            bitpos = int'(QUO_W) - 1 - int'(STAGE * DIV_STEPS) - j;
            trial  = '0;
            if (bitpos >= 0) begin
                trial = NUM_W'(n_bus.den) << bitpos;
                if (n_bus.rem >= trial) begin
                    n_bus.rem         = n_bus.rem - trial;
                    n_bus.quo[bitpos] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bus <= n_bus;
        end
    end

    assign o_bus = r_bus;

endmodule

`default_nettype wire

// File: hdl/skin_pixel_classifier_top.sv
// ----------------------------------------------------------------------------
// skin_pixel_classifier_top: RGB skin rule with HSV hue window
// Marks skin pixels by clearing red and green; other pixels pass unchanged.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Payload
//  s         in         i_s_tvalid/o_s_tready  tdata: red, green, blue
//  m         out        o_m_tvalid/i_m_tready  tdata: red, green, blue; tuser: is_skin
//  cfg       in         i_cfg_valid/o_cfg_ready index 0 hue_low_limit, 1 hue_high_limit
//
//  One item per clock is accepted while the output does not stall; each
//  item is registered after min/max and rule, hue numerator, three divider
//  stages of three quotient bits each, and hue window with output select.
//  Reset is synchronous and clears the stage valid bits and sets both hue
//  limits to their defaults. A stalled output holds only the stages behind
//  it that are full; empty stages keep filling.
// ----------------------------------------------------------------------------
`default_nettype none

module skin_pixel_classifier_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // s: red [7:0], green [15:8], blue [23:16]
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [23:0]                     i_s_tdata,
    // m: red_out [7:0], green_out [15:8], blue_out [23:16]
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [23:0]                     o_m_tdata,
    // m: is_skin [0]
    output logic                            o_m_tuser,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [spc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [spc_pkg::HUE_W-1:0]       i_cfg_data
);
    import spc_pkg::*;

    localparam int unsigned NSTG   = DIV_STAGES + 3;
    localparam int unsigned OUT_ST = NSTG - 1;

    logic [NSTG-1:0]    r_valid;
    logic [NSTG-1:0]    stg_en;
    t_pix               r_pix [OUT_ST];
    t_max_sel           r_sel;
    logic [PIX_W-1:0]   r_den;
    t_div_bus           w_div [DIV_STAGES+1];
    t_div_bus           r_div;
    logic [HUE_W-1:0]   r_hue_low;
    logic [HUE_W-1:0]   r_hue_high;
    logic [3*PIX_W-1:0] r_out_data;
    logic               r_out_skin;

    // Stage 0 combinational signals.
    logic [PIX_W-1:0]   red;
    logic [PIX_W-1:0]   green;
    logic [PIX_W-1:0]   blue;
    logic [PIX_W-1:0]   mx;
    logic [PIX_W-1:0]   mn;
    logic [PIX_W-1:0]   spread;
    logic [PIX_W-1:0]   rg_abs;
    logic               day_ok;
    logic               flash_ok;
    t_max_sel           n_sel;
    t_pix               n_pix;

    // Stage 1 combinational signals.
    logic [PIX_W-1:0]   op_a;
    logic [PIX_W-1:0]   op_c;
    logic [HUE_W-1:0]   base;
    logic signed [CALC_W-1:0] diff_s;
    logic signed [CALC_W-1:0] num_s;
    t_div_bus           n_div;

    // Output stage combinational signals.
    t_div_bus           div_q;
    logic [HUE_W-1:0]   hue;
    logic               hue_ok;
    logic               skin;

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb begin
        stg_en[OUT_ST] = !r_valid[OUT_ST] || i_m_tready;
        for (int k = int'(OUT_ST) - 1; k >= 0; k--) begin
            stg_en[k] = !r_valid[k] || stg_en[k+1];
        end
    end

    assign o_s_tready = stg_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (stg_en[0]) begin
                r_valid[0] <= i_s_tvalid;
            end
            for (int k = 1; k < int'(NSTG); k++) begin
                if (stg_en[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    // Stage 0: extremes, spread and the two-branch RGB rule.
    assign red   = i_s_tdata[PIX_W-1:0];
    assign green = i_s_tdata[2*PIX_W-1:PIX_W];
    assign blue  = i_s_tdata[3*PIX_W-1:2*PIX_W];

    always_comb begin
        if (red >= green && red >= blue) begin
            n_sel = MAX_RED;
            mx    = red;
        end else if (green >= blue) begin
            n_sel = MAX_GREEN;
            mx    = green;
        end else begin
            n_sel = MAX_BLUE;
            mx    = blue;
        end
        mn = (red <= green) ? red : green;
        mn = (mn <= blue) ? mn : blue;
        spread = mx - mn;
        rg_abs = (red >= green) ? red - green : green - red;
        day_ok = (red > DAY_R_MIN) && (green > DAY_G_MIN) && (blue > DAY_B_MIN) &&
                 (spread > DIFF_LIMIT) && (rg_abs > DIFF_LIMIT) &&
                 (red > green) && (red > blue);
        flash_ok = (red > FLASH_R_MIN) && (green > FLASH_G_MIN) &&
                   (blue > FLASH_B_MIN) && (rg_abs <= DIFF_LIMIT) &&
                   (red > blue) && (green > blue);
        n_pix.red    = red;
        n_pix.green  = green;
        n_pix.blue   = blue;
        n_pix.rgb_ok = day_ok || flash_ok;
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[0]) begin
            r_pix[0] <= n_pix;
            r_sel    <= n_sel;
            r_den    <= spread;
        end
        for (int k = 1; k < int'(OUT_ST); k++) begin
            if (stg_en[k]) begin
                r_pix[k] <= r_pix[k-1];
            end
        end
    end

    // Stage 1: hue numerator 60*(a-c) + base*d, never negative.
    always_comb begin
        unique case (r_sel)
            MAX_RED: begin
                op_a = r_pix[0].green;
                op_c = r_pix[0].blue;
                base = BASE_RED;
            end
            MAX_GREEN: begin
                op_a = r_pix[0].blue;
                op_c = r_pix[0].red;
                base = BASE_GREEN;
            end
            MAX_BLUE: begin
                op_a = r_pix[0].red;
                op_c = r_pix[0].green;
                base = BASE_BLUE;
            end
            default: begin
                op_a = '0;
                op_c = '0;
                base = '0;
            end
        endcase
        diff_s = $signed({{(CALC_W-PIX_W){1'b0}}, op_a}) -
                 $signed({{(CALC_W-PIX_W){1'b0}}, op_c});
        num_s  = diff_s * $signed({{(CALC_W-HUE_W){1'b0}}, HUE_SCALE}) +
                 $signed({{(CALC_W-PIX_W){1'b0}}, r_den}) *
                 $signed({{(CALC_W-HUE_W){1'b0}}, base});
        n_div.rem = num_s[NUM_W-1:0];
        n_div.den = r_den;
        n_div.quo = '0;
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[1]) begin
            r_div <= n_div;
        end
    end

    assign w_div[0] = r_div;

    for (genvar s = 0; s < int'(DIV_STAGES); s++) begin : g_div
        spc_div_stage #(
            .STAGE (s)
        ) u_div_stage (
            .i_clk (i_clk),
            .i_en  (stg_en[s+2]),
            .i_bus (w_div[s]),
            .o_bus (w_div[s+1])
        );
    end

    // Output stage: wrap the hue, apply the window and select the pixel.
    always_comb begin
        div_q = w_div[DIV_STAGES];
        if (div_q.den == '0) begin
            hue = '0;
        end else if (div_q.quo >= HUE_FULL) begin
            hue = div_q.quo - HUE_FULL;
        end else begin
            hue = div_q.quo;
        end
        hue_ok = (hue < r_hue_low) || (hue > r_hue_high);
        skin   = r_pix[OUT_ST-1].rgb_ok && hue_ok;
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[OUT_ST]) begin
            r_out_skin <= skin;
            r_out_data <= {r_pix[OUT_ST-1].blue,
                           skin ? {PIX_W{1'b0}} : r_pix[OUT_ST-1].green,
                           skin ? {PIX_W{1'b0}} : r_pix[OUT_ST-1].red};
        end
    end

    assign o_m_tvalid = r_valid[OUT_ST];
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_skin;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_low  <= HUE_LOW_RESET;
            r_hue_high <= HUE_HIGH_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_HUE_LOW:  r_hue_low  <= i_cfg_data;
                CFG_HUE_HIGH: r_hue_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hdl/spc_checker.sv
// ----------------------------------------------------------------------------
// spc_checker: port-level checks of the skin pixel classifier
// Watches the stream and configuration ports of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module spc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_valid,
    input logic        i_s_tready,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] i_m_tdata,
    input logic        i_m_tuser,
    input logic        i_cfg_ready
);
    import spc_pkg::*;

    // A skin item always leaves with red and green cleared.
    a_skin_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && i_m_tuser) |-> (i_m_tdata[2*PIX_W-1:0] == '0))
        else $error("skin item with red or green not cleared");

    // A grey item fails both branches of the RGB rule.
    a_grey_not_skin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && (i_m_tdata[PIX_W-1:0] == i_m_tdata[2*PIX_W-1:PIX_W]) &&
         (i_m_tdata[PIX_W-1:0] == i_m_tdata[3*PIX_W-1:2*PIX_W])) |-> !i_m_tuser)
        else $error("grey item classed as skin");

    // The input side only stalls when the output holds an item that is not taken.
    a_stall_from_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_s_tready |-> (i_m_tvalid && !i_m_tready))
        else $error("input stalled without an output stall");

    // A result that is not taken stays on the port unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |=>
        (i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser)))
        else $error("output item changed while stalled");

    // Configuration writes are never refused.
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> i_cfg_ready)
        else $error("configuration port not ready");

endmodule

bind skin_pixel_classifier_top spc_checker u_spc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_valid (i_cfg_valid),
    .i_s_tready  (o_s_tready),
    .i_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .i_m_tdata   (o_m_tdata),
    .i_m_tuser   (o_m_tuser),
    .i_cfg_ready (o_cfg_ready)
);

`default_nettype wire
